@@ hw/rtl/srrc_pkg.sv @@
// ----------------------------------------------------------------------------
// srrc_pkg
// Shared types, constants and character matching helpers for the resolution
// reply checker.
// ----------------------------------------------------------------------------
package srrc_pkg;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_REQ_KEY,
        PH_REQ_VAL,
        PH_TR_START,
        PH_TR_KEY,
        PH_TR_VAL
    } phase_t;

    typedef enum logic [1:0] {
        VIA_PREFIX,
        VIA_NAME,
        VIA_NUMBER
    } via_t;

    typedef enum logic [2:0] {
        REG_RESPONSE_CODE,
        REG_NAME_LIMIT,
        REG_VERSION_LIMIT,
        REG_VIA_PREFIX_LIMIT,
        REG_SPX_LIMIT,
        REG_RECORD_LIMIT
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  response_code;
        logic [10:0] name_limit;
        logic [6:0]  version_limit;
        logic [6:0]  via_prefix_limit;
        logic [10:0] spx_limit;
        logic [10:0] record_limit;
    } cfg_t;

    localparam int CFG_DATA_W = 11;

    localparam logic [7:0]  RST_RESPONSE_CODE    = 8'd5;
    localparam logic [10:0] RST_NAME_LIMIT       = 11'd255;
    localparam logic [6:0]  RST_VERSION_LIMIT    = 7'd16;
    localparam logic [6:0]  RST_VIA_PREFIX_LIMIT = 7'd15;
    localparam logic [10:0] RST_SPX_LIMIT        = 11'd1024;
    localparam logic [10:0] RST_RECORD_LIMIT     = 11'd1024;

    localparam logic [16:0] COUNT_MAX = 17'd131071;
    localparam logic [11:0] LEN_MAX   = 12'd4095;
    localparam logic [35:0] TCP_PORT_MAX = 36'd65535;
    localparam logic [35:0] VIA_NUM_MAX  = 36'hFFFFFFFF;

    // Transport kinds are the index of the transport key in its list.
    localparam logic [2:0] KIND_TCP = 3'd1;
    localparam logic [2:0] KIND_VIA = 3'd2;
    localparam logic [2:0] KIND_SPX = 3'd4;
    localparam logic [2:0] KIND_BV  = 3'd6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // Word identifiers: four required keys, two booleans, seven transports.
    localparam logic [3:0] W_SERVERNAME   = 4'd0;
    localparam logic [3:0] W_INSTANCENAME = 4'd1;
    localparam logic [3:0] W_ISCLUSTERED  = 4'd2;
    localparam logic [3:0] W_VERSION      = 4'd3;
    localparam logic [3:0] W_YES          = 4'd4;
    localparam logic [3:0] W_NO           = 4'd5;
    localparam logic [3:0] W_NP           = 4'd6;
    localparam logic [3:0] W_TCP          = 4'd7;
    localparam logic [3:0] W_VIA          = 4'd8;
    localparam logic [3:0] W_RPC          = 4'd9;
    localparam logic [3:0] W_SPX          = 4'd10;
    localparam logic [3:0] W_ADSP         = 4'd11;
    localparam logic [3:0] W_BV           = 4'd12;

    function automatic logic [7:0] lower_char(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
    endfunction

    function automatic logic [3:0] word_len(input logic [3:0] id);
        logic [3:0] len;
        case (id)
            W_SERVERNAME:   len = 4'd10;
            W_INSTANCENAME: len = 4'd12;
            W_ISCLUSTERED:  len = 4'd11;
            W_VERSION:      len = 4'd7;
            W_YES:          len = 4'd3;
            W_NO:           len = 4'd2;
            W_NP:           len = 4'd2;
            W_TCP:          len = 4'd3;
            W_VIA:          len = 4'd3;
            W_RPC:          len = 4'd3;
            W_SPX:          len = 4'd3;
            W_ADSP:         len = 4'd4;
            W_BV:           len = 4'd2;
            default:        len = 4'd0;
        endcase
        return len;
    endfunction

    // Words are right-aligned: the last character sits in the low byte.
    function automatic logic [95:0] word_text(input logic [3:0] id);
        logic [95:0] s;
        case (id)
            W_SERVERNAME:   s = 96'("servername");
            W_INSTANCENAME: s = 96'("instancename");
            W_ISCLUSTERED:  s = 96'("isclustered");
            W_VERSION:      s = 96'("version");
            W_YES:          s = 96'("yes");
            W_NO:           s = 96'("no");
            W_NP:           s = 96'("np");
            W_TCP:          s = 96'("tcp");
            W_VIA:          s = 96'("via");
            W_RPC:          s = 96'("rpc");
            W_SPX:          s = 96'("spx");
            W_ADSP:         s = 96'("adsp");
            W_BV:           s = 96'("bv");
            default:        s = '0;
        endcase
        return s;
    endfunction

    function automatic logic word_hit(input logic [3:0] id, input logic [11:0] pos,
                                      input logic [7:0] c);
        logic [3:0]  len;
        logic [95:0] s;
        logic [3:0]  idx;
        len = word_len(id);
        s   = word_text(id);
        idx = len - 4'd1 - pos[3:0];
        if (pos >= {8'd0, len}) begin
            return 1'b0;
        end
        return s[{idx, 3'b000} +: 8] == lower_char(c);
    endfunction

endpackage

@@ hw/rtl/srrc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// srrc_cfg_regs
// Write-only configuration registers with their reset values.
// ----------------------------------------------------------------------------
module srrc_cfg_regs
    import srrc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.response_code    <= RST_RESPONSE_CODE;
            cfg_reg.name_limit       <= RST_NAME_LIMIT;
            cfg_reg.version_limit    <= RST_VERSION_LIMIT;
            cfg_reg.via_prefix_limit <= RST_VIA_PREFIX_LIMIT;
            cfg_reg.spx_limit        <= RST_SPX_LIMIT;
            cfg_reg.record_limit     <= RST_RECORD_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RESPONSE_CODE:    cfg_reg.response_code    <= cfg_wdata[7:0];
                REG_NAME_LIMIT:       cfg_reg.name_limit       <= cfg_wdata[10:0];
                REG_VERSION_LIMIT:    cfg_reg.version_limit    <= cfg_wdata[6:0];
                REG_VIA_PREFIX_LIMIT: cfg_reg.via_prefix_limit <= cfg_wdata[6:0];
                REG_SPX_LIMIT:        cfg_reg.spx_limit        <= cfg_wdata[10:0];
                REG_RECORD_LIMIT:     cfg_reg.record_limit     <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/srrc_parser.sv @@
// ----------------------------------------------------------------------------
// srrc_parser
// Per-byte parse of the reply datagram; emits the verdict on the last byte.
// ----------------------------------------------------------------------------
module srrc_parser
    import srrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    output logic       res_ok
);

    phase_t      phase_reg, phase_next;
    logic [16:0] byte_count_reg, byte_count_next;
    logic [15:0] declared_reg, declared_next;
    logic [1:0]  req_idx_reg, req_idx_next;
    logic [11:0] field_len_reg, field_len_next;
    logic [6:0]  mask_reg, mask_next;
    logic [6:0]  seen_reg, seen_next;
    logic [2:0]  kind_reg, kind_next;
    logic [2:0]  values_left_reg, values_left_next;
    logic [31:0] dec_reg, dec_next;
    via_t        via_reg, via_next;
    logic [11:0] record_len_reg, record_len_next;
    logic        value_ok_reg, value_ok_next;
    logic        inst_seen_reg, inst_seen_next;
    logic        failed_reg, failed_next;
    logic        ok_now;

    always_comb begin
        logic [7:0]  c;
        logic        bad;
        logic        is_digit;
        logic        found;
        logic [2:0]  k;
        logic [35:0] dec_v;
        logic [35:0] dec_lim;
        logic [6:0]  m;
        logic [16:0] pay_pos;

        c        = in_byte;
        bad      = 1'b0;
        is_digit = c inside {[CH_0:CH_9]};
        found    = 1'b0;
        k        = '0;
        m        = '0;
        dec_v    = ({1'b0, dec_reg, 3'b000}) + ({3'b000, dec_reg, 1'b0}) + {32'd0, c[3:0]};
        dec_lim  = (kind_reg == KIND_TCP) ? TCP_PORT_MAX : VIA_NUM_MAX;
        pay_pos  = byte_count_reg - 17'd3;

        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        declared_next    = declared_reg;
        req_idx_next     = req_idx_reg;
        field_len_next   = field_len_reg;
        mask_next        = mask_reg;
        seen_next        = seen_reg;
        kind_next        = kind_reg;
        values_left_next = values_left_reg;
        dec_next         = dec_reg;
        via_next         = via_reg;
        record_len_next  = record_len_reg;
        value_ok_next    = value_ok_reg;
        inst_seen_next   = inst_seen_reg;
        failed_next      = failed_reg;

        if (byte_count_reg == 17'd0) begin
            if (c != cfg.response_code) failed_next = 1'b1;
        end else if (byte_count_reg == 17'd1) begin
            declared_next = {8'd0, c};
        end else if (byte_count_reg == 17'd2) begin
            declared_next  = {c, declared_reg[7:0]};
            phase_next     = PH_REQ_KEY;
            field_len_next = '0;
            mask_next      = '1;
            value_ok_next  = 1'b1;
            dec_next       = '0;
            via_next       = VIA_PREFIX;
        end else if (!failed_reg) begin
            if (pay_pos >= {1'b0, declared_reg} || c == CH_NUL) begin
                bad = 1'b1;
            end else begin
                if (record_len_reg < LEN_MAX) record_len_next = record_len_reg + 12'd1;
                // A finished field resets the per-field state.
                case (phase_reg)
                    PH_REQ_KEY: begin
                        if (c != CH_SEMI) begin
                            mask_next = {6'd0, mask_reg[0] &
                                word_hit({2'b00, req_idx_reg}, field_len_reg, c)};
                            if (field_len_reg < LEN_MAX) field_len_next = field_len_reg + 12'd1;
                        end else if (!(mask_reg[0] &&
                                   {8'd0, word_len({2'b00, req_idx_reg})} == field_len_reg)) begin
                            bad = 1'b1;
                        end else begin
                            field_len_next = '0;
                            mask_next      = '1;
                            value_ok_next  = 1'b1;
                            dec_next       = '0;
                            via_next       = VIA_PREFIX;
                            phase_next     = PH_REQ_VAL;
                        end
                    end
                    PH_REQ_VAL: begin
                        if (c != CH_SEMI) begin
                            if (req_idx_reg == 2'd2) begin
                                mask_next = {5'd0,
                                    mask_reg[1] & word_hit(W_NO, field_len_reg, c),
                                    mask_reg[0] & word_hit(W_YES, field_len_reg, c)};
                            end
                            if (req_idx_reg == 2'd3 && c != CH_DOT && !is_digit) begin
                                value_ok_next = 1'b0;
                            end
                            if (field_len_reg < LEN_MAX) field_len_next = field_len_reg + 12'd1;
                        end else begin
                            if (req_idx_reg < 2'd2) begin
                                bad = field_len_reg > {1'b0, cfg.name_limit};
                            end else if (req_idx_reg == 2'd2) begin
                                bad = !((mask_reg[0] &&
                                         field_len_reg == {8'd0, word_len(W_YES)}) ||
                                        (mask_reg[1] &&
                                         field_len_reg == {8'd0, word_len(W_NO)}));
                            end else begin
                                bad = !(value_ok_reg && field_len_reg != '0 &&
                                        field_len_reg <= {5'd0, cfg.version_limit});
                            end
                            field_len_next = '0;
                            mask_next      = '1;
                            value_ok_next  = 1'b1;
                            dec_next       = '0;
                            via_next       = VIA_PREFIX;
                            if (req_idx_reg < 2'd3) begin
                                req_idx_next = req_idx_reg + 2'd1;
                                phase_next   = PH_REQ_KEY;
                            end else begin
                                phase_next = PH_TR_START;
                            end
                        end
                    end
                    PH_TR_START: begin
                        field_len_next = '0;
                        mask_next      = '1;
                        value_ok_next  = 1'b1;
                        dec_next       = '0;
                        via_next       = VIA_PREFIX;
                        if (c == CH_SEMI) begin
                            if (record_len_next > {1'b0, cfg.record_limit}) begin
                                bad = 1'b1;
                            end else begin
                                inst_seen_next  = 1'b1;
                                record_len_next = '0;
                                req_idx_next    = '0;
                                seen_next       = '0;
                                phase_next      = PH_REQ_KEY;
                            end
                        end else begin
                            for (int i = 0; i < 7; i++) begin
                                m[i] = word_hit(W_NP + 4'(i), 12'd0, c);
                            end
                            mask_next      = m;
                            field_len_next = 12'd1;
                            phase_next     = PH_TR_KEY;
                        end
                    end
                    PH_TR_KEY: begin
                        if (c != CH_SEMI) begin
                            for (int i = 0; i < 7; i++) begin
                                m[i] = mask_reg[i] & word_hit(W_NP + 4'(i), field_len_reg, c);
                            end
                            mask_next = m;
                            if (field_len_reg < LEN_MAX) field_len_next = field_len_reg + 12'd1;
                        end else begin
                            for (int i = 6; i >= 0; i--) begin
                                if (mask_reg[i] &&
                                    {8'd0, word_len(W_NP + 4'(i))} == field_len_reg) begin
                                    found = 1'b1;
                                    k     = 3'(i);
                                end
                            end
                            if (!found || seen_reg[k]) begin
                                bad = 1'b1;
                            end else begin
                                seen_next[k]     = 1'b1;
                                kind_next        = k;
                                values_left_next = (k == KIND_BV) ? 3'd5 : 3'd1;
                                field_len_next   = '0;
                                mask_next        = '1;
                                value_ok_next    = 1'b1;
                                dec_next         = '0;
                                via_next         = VIA_PREFIX;
                                phase_next       = PH_TR_VAL;
                            end
                        end
                    end
                    PH_TR_VAL: begin
                        if (c != CH_SEMI) begin
                            if (kind_reg == KIND_VIA && via_reg == VIA_PREFIX && c == CH_COMMA) begin
                                bad = field_len_reg > {5'd0, cfg.via_prefix_limit};
                                via_next       = VIA_NAME;
                                field_len_next = '0;
                            end else if (kind_reg == KIND_VIA && via_reg == VIA_NAME &&
                                         c == CH_COMMA) begin
                                bad = 1'b1;
                            end else if (kind_reg == KIND_VIA && via_reg == VIA_NAME &&
                                         c == CH_COLON) begin
                                bad = field_len_reg == '0;
                                via_next       = VIA_NUMBER;
                                field_len_next = '0;
                                dec_next       = '0;
                            end else if (kind_reg == KIND_VIA && via_reg == VIA_NUMBER &&
                                         c == CH_COMMA) begin
                                bad = field_len_reg == '0;
                                via_next       = VIA_NAME;
                                field_len_next = '0;
                            end else begin
                                if (field_len_reg < LEN_MAX) field_len_next = field_len_reg + 12'd1;
                                // Port and via numbers accumulate in decimal.
                                if (kind_reg == KIND_TCP ||
                                    (kind_reg == KIND_VIA && via_reg == VIA_NUMBER)) begin
                                    if (!is_digit || dec_v > dec_lim) begin
                                        bad = 1'b1;
                                    end else begin
                                        dec_next = dec_v[31:0];
                                    end
                                end
                            end
                        end else begin
                            if (kind_reg == KIND_TCP) begin
                                bad = field_len_reg == '0 || dec_reg == '0;
                            end else if (kind_reg == KIND_VIA) begin
                                bad = via_reg != VIA_NUMBER || field_len_reg == '0;
                            end else if (kind_reg == KIND_SPX) begin
                                bad = field_len_reg > {1'b0, cfg.spx_limit};
                            end
                            field_len_next = '0;
                            mask_next      = '1;
                            value_ok_next  = 1'b1;
                            dec_next       = '0;
                            via_next       = VIA_PREFIX;
                            if (values_left_reg > 3'd0) values_left_next = values_left_reg - 3'd1;
                            if (values_left_next == 3'd0) phase_next = PH_TR_START;
                        end
                    end
                    default: bad = 1'b1;
                endcase
            end
            if (bad) failed_next = 1'b1;
        end

        if (byte_count_reg < COUNT_MAX) byte_count_next = byte_count_reg + 17'd1;

        ok_now = !failed_next && byte_count_next >= 17'd3 &&
                 (byte_count_next - 17'd3) == {1'b0, declared_next} &&
                 phase_next == PH_REQ_KEY && record_len_next == '0 && inst_seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && in_last)) begin
            phase_reg       <= PH_HEADER;
            byte_count_reg  <= '0;
            declared_reg    <= '0;
            req_idx_reg     <= '0;
            field_len_reg   <= '0;
            mask_reg        <= '1;
            seen_reg        <= '0;
            kind_reg        <= '0;
            values_left_reg <= '0;
            dec_reg         <= '0;
            via_reg         <= VIA_PREFIX;
            record_len_reg  <= '0;
            value_ok_reg    <= 1'b1;
            inst_seen_reg   <= 1'b0;
            failed_reg      <= 1'b0;
        end else if (in_fire) begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            declared_reg    <= declared_next;
            req_idx_reg     <= req_idx_next;
            field_len_reg   <= field_len_next;
            mask_reg        <= mask_next;
            seen_reg        <= seen_next;
            kind_reg        <= kind_next;
            values_left_reg <= values_left_next;
            dec_reg         <= dec_next;
            via_reg         <= via_next;
            record_len_reg  <= record_len_next;
            value_ok_reg    <= value_ok_next;
            inst_seen_reg   <= inst_seen_next;
            failed_reg      <= failed_next;
        end
    end

    assign res_valid = in_fire && in_last;
    assign res_ok    = ok_now;

endmodule

@@ hw/rtl/srrc_out_buf.sv @@
// ----------------------------------------------------------------------------
// srrc_out_buf
// Two-entry verdict buffer between the parser and the result channel.
// ----------------------------------------------------------------------------
module srrc_out_buf
    import srrc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  logic push_data,
    output logic room,
    output logic out_valid,
    output logic out_data,
    input  logic out_ready
);

    logic [1:0] count_reg, count_next;
    logic       slot0_reg, slot0_next;
    logic       slot1_reg, slot1_next;
    logic       pop;
    logic [1:0] after_pop;

    assign pop       = out_valid && out_ready;
    assign after_pop = count_reg - {1'b0, pop};

    always_comb begin
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        count_next = after_pop + {1'b0, push};
        if (push) begin
            if (after_pop == 2'd0) begin
                slot0_next = push_data;
            end else begin
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign room      = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = slot0_reg;

endmodule

@@ hw/rtl/sql_resolution_reply_checker.sv @@
// A verdict is buffered when its last byte is accepted; m_tdata shows it in order.
// One byte per cycle unless s_tready is low; parser state updates per accepted byte.
// A two-entry verdict buffer keeps s_tready high while one verdict waits.
// Reset (aresetn low, synchronous) restores the register defaults and clears
// the parse state and the verdict buffer; no clearing pass is needed.
// ----------------------------------------------------------------------------
// sql_resolution_reply_checker
// Validates resolution protocol reply datagrams streamed one byte at a time.
// ----------------------------------------------------------------------------
module sql_resolution_reply_checker
    import srrc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // [0] accepted, [7:1] zero
);

    cfg_t cfg;
    logic in_fire;
    logic res_valid;
    logic res_ok;
    logic room;
    logic verdict;

    assign s_tready = room;
    assign in_fire  = s_tvalid && room;

    srrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    srrc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res_ok    (res_ok)
    );

    srrc_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res_ok),
        .room      (room),
        .out_valid (m_tvalid),
        .out_data  (verdict),
        .out_ready (m_tready)
    );

    assign m_tdata = {7'd0, verdict};

endmodule

@@ hw/rtl/srrc_checker.sv @@
// ----------------------------------------------------------------------------
// srrc_checker
// Port-level assertions for the reply checker, bound to the top level.
// ----------------------------------------------------------------------------
module srrc_checker
    import srrc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // The buffer comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Input back-pressure only happens when verdicts are waiting.
    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // A new verdict follows an accepted final byte.
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a final byte");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A waiting input request keeps its byte and marker until it is taken.
    a_request_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("stalled request changed");

endmodule

bind sql_resolution_reply_checker srrc_checker u_srrc_checker (.*);

@@ tb/tb_sql_resolution_reply_checker.sv @@
// ----------------------------------------------------------------------------
// tb_sql_resolution_reply_checker
// Streams resolution reply datagrams into the checker and compares each
// verdict with an in-bench parser: directed header, transport and length
// cases, a name limit, output back-pressure, then randomized replies under
// several register settings.
// ----------------------------------------------------------------------------
module tb_sql_resolution_reply_checker;
    timeunit 1ns;
    timeprecision 1ps;
    import srrc_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] data_byte
    logic                  s_tlast;   // last_byte
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // [0] accepted, [7:1] zero

    sql_resolution_reply_checker u_dut (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // Register copies used by the parser model.
    int unsigned c_code, c_name, c_version, c_via, c_spx, c_record;

    // Parser model state.
    phase_t      ph;
    via_t        vph;
    int unsigned bcnt, dlen, ridx, flen, mask, tseen, tkind, vleft, rlen;
    longint unsigned dval;
    bit          vok, iseen, fail;

    string req_w[4] = '{"servername", "instancename", "isclustered", "version"};
    string bool_w[2] = '{"yes", "no"};
    string tr_w[7] = '{"np", "tcp", "via", "rpc", "spx", "adsp", "bv"};

    bit          verdict_q[$];
    bit [7:0]    pay[$];
    bit [7:0]    frm[$];
    int          errors = 0;
    int          n_bytes = 0, n_dgrams = 0, n_ok = 0, n_bad = 0;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;
    bit          rst_done = 1'b0;

    function automatic bit [7:0] lc(bit [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
    endfunction

    function automatic string word_of(int list, int i);
        if (list == 0) return req_w[i];
        if (list == 1) return bool_w[i];
        return tr_w[i];
    endfunction

    function automatic int unsigned narrow(int unsigned m, int list, int base, int n,
                                           int unsigned pos, bit [7:0] c);
        string w;
        for (int i = 0; i < n; i++) begin
            w = word_of(list, base + i);
            if (pos >= w.len() || lc(c) != w[pos]) m &= ~(1 << i);
        end
        return m;
    endfunction

    function automatic bit whole(int unsigned m, int list, int base, int n,
                                 output int unsigned k);
        string w;
        k = 0;
        for (int i = 0; i < n; i++) begin
            w = word_of(list, base + i);
            if (m[i] && w.len() == flen) begin
                k = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void clear_parse();
        ph = PH_HEADER; bcnt = 0; dlen = 0; ridx = 0; flen = 0; mask = 'h7F;
        tseen = 0; tkind = 0; vleft = 0; dval = 0; vph = VIA_PREFIX; rlen = 0;
        vok = 1; iseen = 0; fail = 0;
    endfunction

    function automatic void grow();
        if (flen < 4095) flen++;
    endfunction

    function automatic void start_field();
        flen = 0; mask = 'h7F; vok = 1; dval = 0; vph = VIA_PREFIX;
    endfunction

    function automatic bit add_digit(bit [7:0] c, longint unsigned limit);
        longint unsigned v;
        if (c < CH_0 || c > CH_9) return 1'b0;
        v = dval * 10 + (c - CH_0);
        if (v > limit) return 1'b0;
        dval = v;
        return 1'b1;
    endfunction

    function automatic bit req_value_done();
        int unsigned k;
        if (ridx < 2) return flen <= c_name;
        if (ridx == 2) return whole(mask & 3, 1, 0, 2, k);
        return vok && flen >= 1 && flen <= c_version;
    endfunction

    function automatic bit tr_value_char(bit [7:0] c);
        if (tkind == KIND_TCP) begin
            grow();
            return add_digit(c, 65535);
        end
        if (tkind != KIND_VIA) begin
            grow();
            return 1'b1;
        end
        if (vph == VIA_PREFIX) begin
            if (c == CH_COMMA) begin
                if (flen > c_via) return 1'b0;
                vph = VIA_NAME; flen = 0;
            end else grow();
            return 1'b1;
        end
        if (vph == VIA_NAME) begin
            if (c == CH_COMMA) return 1'b0;
            if (c == CH_COLON) begin
                if (flen == 0) return 1'b0;
                vph = VIA_NUMBER; flen = 0; dval = 0;
            end else grow();
            return 1'b1;
        end
        if (c == CH_COMMA) begin
            if (flen == 0) return 1'b0;
            vph = VIA_NAME; flen = 0;
            return 1'b1;
        end
        grow();
        return add_digit(c, 64'hFFFF_FFFF);
    endfunction

    function automatic bit tr_value_done();
        if (tkind == KIND_TCP) return flen != 0 && dval != 0;
        if (tkind == KIND_VIA) return vph == VIA_NUMBER && flen != 0;
        if (tkind == KIND_SPX) return flen <= c_spx;
        return 1'b1;
    endfunction

    function automatic bit parse_payload(bit [7:0] c);
        int unsigned k;
        if (c == CH_NUL) return 1'b0;
        if (rlen < 4095) rlen++;
        case (ph)
            PH_REQ_KEY: begin
                if (c != CH_SEMI) begin
                    mask = narrow(mask & 1, 0, ridx, 1, flen, c);
                    grow();
                    return 1'b1;
                end
                if (!whole(mask & 1, 0, ridx, 1, k)) return 1'b0;
                start_field();
                ph = PH_REQ_VAL;
                return 1'b1;
            end
            PH_REQ_VAL: begin
                if (c != CH_SEMI) begin
                    if (ridx == 2) mask = narrow(mask & 3, 1, 0, 2, flen, c);
                    if (ridx == 3 && c != CH_DOT && (c < CH_0 || c > CH_9)) vok = 0;
                    grow();
                    return 1'b1;
                end
                if (!req_value_done()) return 1'b0;
                start_field();
                if (ridx < 3) begin
                    ridx++;
                    ph = PH_REQ_KEY;
                end else ph = PH_TR_START;
                return 1'b1;
            end
            PH_TR_START: begin
                if (c == CH_SEMI) begin
                    if (rlen > c_record) return 1'b0;
                    iseen = 1; rlen = 0; ridx = 0; tseen = 0;
                    start_field();
                    ph = PH_REQ_KEY;
                    return 1'b1;
                end
                start_field();
                ph = PH_TR_KEY;
                mask = narrow(mask, 2, 0, 7, flen, c);
                grow();
                return 1'b1;
            end
            PH_TR_KEY: begin
                if (c != CH_SEMI) begin
                    mask = narrow(mask, 2, 0, 7, flen, c);
                    grow();
                    return 1'b1;
                end
                if (!whole(mask, 2, 0, 7, k)) return 1'b0;
                if (tseen[k]) return 1'b0;
                tseen |= 1 << k;
                tkind = k;
                vleft = (k == KIND_BV) ? 5 : 1;
                start_field();
                ph = PH_TR_VAL;
                return 1'b1;
            end
            PH_TR_VAL: begin
                if (c != CH_SEMI) return tr_value_char(c);
                if (!tr_value_done()) return 1'b0;
                start_field();
                if (vleft > 0) vleft--;
                if (vleft == 0) ph = PH_TR_START;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Returns 1 when the byte ends a datagram; verdict then holds the outcome.
    function automatic bit predict_byte(bit [7:0] c, bit last, output bit verdict);
        verdict = 0;
        if (bcnt == 0) begin
            if (c != c_code) fail = 1;
        end else if (bcnt == 1) begin
            dlen = c;
        end else if (bcnt == 2) begin
            dlen |= c << 8;
            ph = PH_REQ_KEY;
            start_field();
        end else if (!fail) begin
            if (bcnt - 3 >= dlen) fail = 1;
            else if (!parse_payload(c)) fail = 1;
        end
        if (bcnt < 131071) bcnt++;
        if (!last) return 1'b0;
        verdict = !fail && bcnt >= 3 && bcnt - 3 == dlen && ph == PH_REQ_KEY &&
                  rlen == 0 && iseen;
        clear_parse();
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_v);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, exp_v);
        errors++;
    endtask

    // Result side: values are sampled mid-cycle so the edge check is race free.
    logic       mv_n, mr_n;
    logic [7:0] md_n;
    always @(negedge aclk) begin
        mv_n = m_tvalid;
        mr_n = m_tready;
        md_n = m_tdata;
    end

    always @(posedge aclk) begin
        bit exp_v;
        if (rst_done && mv_n && mr_n) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected verdict", md_n, -1);
            end else begin
                exp_v = verdict_q.pop_front();
                if (md_n[0] !== exp_v) report_mismatch("accepted", md_n[0], exp_v);
                if (md_n[7:1] !== 7'd0) report_mismatch("padding", md_n[7:1], 0);
                if (exp_v) n_ok++;
                else n_bad++;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(bit [7:0] b, bit last);
        logic hs;
        bit   v;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            hs = s_tready;
            @(posedge aclk);
        end while (!hs);
        n_bytes++;
        if (predict_byte(b, last, v)) verdict_q.push_back(v);
    endtask

    // Without idling the next datagram follows directly; wait_drain drops valid.
    task automatic send_frame();
        for (int i = 0; i < frm.size(); i++) send_byte(frm[i], i == frm.size() - 1);
        if (idle_en) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        n_dgrams++;
    endtask

    task automatic build_frame(bit [7:0] code, int len_adj);
        int unsigned len;
        len = pay.size() + len_adj;
        frm = {};
        frm.push_back(code);
        frm.push_back(len[7:0]);
        frm.push_back(len[15:8]);
        foreach (pay[i]) frm.push_back(pay[i]);
    endtask

    task automatic send_reply(bit [7:0] code, int len_adj);
        build_frame(code, len_adj);
        send_frame();
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_cfg(int unsigned code, int unsigned name, int unsigned ver,
                             int unsigned via, int unsigned spx, int unsigned rec);
        int unsigned vals[6];
        vals = '{code, name, ver, via, spx, rec};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_wdata <= CFG_DATA_W'(vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        c_code = code; c_name = name; c_version = ver;
        c_via = via; c_spx = spx; c_record = rec;
        @(posedge aclk);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) pay.push_back(s[i]);
    endtask

    // Keys go out with random letter case.
    task automatic put_key(string s);
        bit [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c -= 8'd32;
            pay.push_back(c);
        end
        pay.push_back(CH_SEMI);
    endtask

    task automatic put_text(int n, string pool);
        for (int i = 0; i < n; i++) pay.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    endtask

    function automatic int unsigned cap(int unsigned a, int unsigned b);
        return a < b ? a : b;
    endfunction

    task automatic add_record();
        string alnum, digits;
        int    order[7];
        int    j, t;
        alnum = "abcXYZ019-_.";
        digits = "0123456789";
        put_key("servername");
        put_text($urandom_range(0, cap(c_name, 4)), alnum); pay.push_back(CH_SEMI);
        put_key("instancename");
        put_text($urandom_range(0, cap(c_name, 4)), alnum); pay.push_back(CH_SEMI);
        put_key("isclustered");
        if ($urandom_range(0, 1)) put_key("yes");
        else put_key("no");
        put_key("version");
        put_text($urandom_range(1, cap(c_version, 6)), "0123456789.");
        pay.push_back(CH_SEMI);
        for (int i = 0; i < 7; i++) order[i] = i;
        for (int i = 6; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        foreach (order[i]) begin
            if ($urandom_range(0, 3) == 0) begin
                t = order[i];
                put_key(tr_w[t]);
                if (t == KIND_TCP) begin
                    put_str($sformatf("%0d;", $urandom_range(1, 65535)));
                end else if (t == KIND_VIA) begin
                    put_text($urandom_range(0, cap(c_via, 4)), alnum);
                    repeat ($urandom_range(1, 2)) begin
                        pay.push_back(CH_COMMA);
                        put_text($urandom_range(1, 3), alnum);
                        pay.push_back(CH_COLON);
                        put_text($urandom_range(1, 5), digits);
                    end
                    pay.push_back(CH_SEMI);
                end else if (t == KIND_SPX) begin
                    put_text($urandom_range(0, cap(c_spx, 6)), alnum);
                    pay.push_back(CH_SEMI);
                end else begin
                    repeat (t == KIND_BV ? 5 : 1) begin
                        put_text($urandom_range(0, 3), alnum);
                        pay.push_back(CH_SEMI);
                    end
                end
            end
        end
        pay.push_back(CH_SEMI);
    endtask

    task automatic random_reply();
        int r;
        pay = {};
        if ($urandom_range(0, 9) != 0) add_record();
        build_frame(c_code, 0);
        if ($urandom_range(0, 9) == 0) begin
            frm = {};
            repeat ($urandom_range(1, 20)) frm.push_back($urandom_range(0, 255));
        end else if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, frm.size() - 1);
            case ($urandom_range(0, 4))
                0: frm[r] = $urandom_range(0, 255);
                1: frm.delete(r);
                2: frm.insert(r, $urandom_range(0, 255));
                3: frm[1] = frm[1] + ($urandom_range(0, 1) ? 8'd1 : 8'hFF);
                default: while (frm.size() > r + 1) void'(frm.pop_back());
            endcase
        end
        send_frame();
    endtask

    task automatic test_header_cases();
        frm = '{8'd5};
        send_frame();
        frm = '{8'd5, 8'd0};
        send_frame();
        pay = {};
        send_reply(8'd5, 0);
        put_str("servername;a;instancename;b;isclustered;no;version;1;;");
        send_reply(8'd6, 0);
    endtask

    task automatic test_minimal_reply();
        pay = {};
        put_str("ServerName;H1;INSTANCENAME;Db;IsClustered;YES;Version;15.0.2000.5;;");
        send_reply(8'd5, 0);
    endtask

    task automatic test_transports();
        string base;
        base = "servername;s;instancename;i;isclustered;no;version;1.0;";
        pay = {};
        put_str({base, "np;\\\\s\\pipe;tcp;65535;via;pre,n1:4294967295,n2:0;"});
        put_str("rpc;s;spx;s;adsp;s;bv;a;b;c;d;e;;");
        send_reply(8'd5, 0);
        pay = {}; put_str({base, "tcp;0;;"}); send_reply(8'd5, 0);
        pay = {}; put_str({base, "tcp;1;tcp;2;;"}); send_reply(8'd5, 0);
    endtask

    task automatic test_nul_and_length();
        pay = {};
        put_str("servername;a");
        pay.push_back(CH_NUL);
        put_str(";instancename;b;isclustered;no;version;1;;");
        send_reply(8'd5, 0);
        pay = {};
        put_str("servername;;instancename;;isclustered;no;version;1;;");
        send_reply(8'd5, -1);
    endtask

    // A server name one character past a lowered name limit is rejected.
    task automatic test_long_field();
        wait_drain();
        apply_cfg(8'd5, 8, 16, 15, 1024, 1024);
        pay = {};
        put_str("servername;");
        repeat (9) pay.push_back("q");
        put_str(";instancename;b;isclustered;no;version;1;;");
        send_reply(8'd5, 0);
        wait_drain();
        apply_cfg(8'd5, 255, 16, 15, 1024, 1024);
    endtask

    // Short datagrams fill the verdict buffer while the receiver holds off.
    task automatic test_backpressure();
        wait_drain();
        hold_req = 1'b1;
        wait (!hold_req);
        repeat (8) begin
            frm = '{8'd5};
            send_frame();
        end
        // Sender waits until every verdict is out before going on.
        wait_drain();
    endtask

    task automatic run_random(int n);
        repeat (n) random_reply();
        wait_drain();
    endtask

    task automatic test_config_sweep();
        apply_cfg(8'd255, 2047, 64, 64, 2047, 2047);
        run_random(1);
        apply_cfg(8'd0, 0, 1, 0, 0, 0);
        run_random(1);
        apply_cfg(8'd5, 3, 3, 2, 2, 60);
        run_random(1);
        idle_en = 1'b0;
        apply_cfg(8'd5, 255, 16, 15, 1024, 1024);
        run_random(2);
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        c_code = 5; c_name = 255; c_version = 16; c_via = 15; c_spx = 1024;
        c_record = 1024;
        clear_parse();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        rst_done = 1'b1;
        test_header_cases();
        test_minimal_reply();
        test_transports();
        test_nul_and_length();
        test_long_field();
        test_backpressure();
        wait_drain();
        test_config_sweep();
        wait_drain();
        repeat (10) @(posedge aclk);
        $display("Covered %0d datagrams, %0d bytes, under several register settings.",
                 n_dgrams, n_bytes);
        $display("Verdicts checked: %0d accepted, %0d rejected, %0d mismatches.",
                 n_ok, n_bad, errors);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("[sql_resolution_reply_checker] OK");
        end else begin
            $display("[sql_resolution_reply_checker] ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[sql_resolution_reply_checker] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/srrc_pkg.sv
hw/rtl/srrc_cfg_regs.sv
hw/rtl/srrc_parser.sv
hw/rtl/srrc_out_buf.sv
hw/rtl/sql_resolution_reply_checker.sv
hw/rtl/srrc_checker.sv
tb/tb_sql_resolution_reply_checker.sv
